[rtl/bsua_pkg.sv]
// shared constants, codes and types of the bump and stack unit allocator
package bsua_pkg;

  localparam int MAX_BUFFERS = 16;
  localparam int MAX_BUF_LEN = 1024;
  localparam int STACK_DEPTH = 256;

  localparam int STACK_AW = $clog2(STACK_DEPTH);
  localparam int COUNT_W  = STACK_AW + 1;

  localparam int MODE_W   = 2;
  localparam int ROW_W    = 4;
  localparam int COL_W    = 10;
  localparam int LEN_W    = 11;
  localparam int BUFCNT_W = 5;
  localparam int STATUS_W = 2;
  localparam int ALLOC_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REINIT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_OWNED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUT_OF_SPACE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_STACK_FULL  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BUF_LEN         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_BUFFERS = 2'd1;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } unit_t;

endpackage

[rtl/bsua_if.sv]
// valid/ready channel interfaces for requests, results and configuration
interface bsua_req_if import bsua_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ROW_W-1:0]  free_row;
  logic [COL_W-1:0]  free_col;
  modport source (output valid, output mode, output free_row, output free_col, input ready);
  modport sink   (input valid, input mode, input free_row, input free_col, output ready);
endinterface

interface bsua_rsp_if import bsua_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ROW_W-1:0]    unit_row;
  logic [COL_W-1:0]    unit_col;
  logic [ALLOC_W-1:0]  units_allocated;
  logic [COUNT_W-1:0]  returned_count;
  modport source (output valid, output status, output unit_row, output unit_col,
                  output units_allocated, output returned_count, input ready);
  modport sink   (input valid, input status, input unit_row, input unit_col,
                  input units_allocated, input returned_count, output ready);
endinterface

interface bsua_cfg_if import bsua_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/bump_and_stack_unit_allocator.sv]
// bump allocator with a returned-units stack held in a single-port-per-side memory
// timing: a bump, free or reinit result is registered and shows in the cycle after
// the request transfer; a stack allocate reads the memory into rd_data, then S_POP
// moves it to the result; no request is taken in S_POP or while a result waits
// reset: synchronous, clears counters, row and column; buffer count resets to one,
// buffer length to MAX_BUF_LEN; the stack memory itself is not cleared
module bump_and_stack_unit_allocator
  import bsua_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  bsua_req_if.sink   req,
  bsua_rsp_if.source rsp,
  bsua_cfg_if.sink   cfg
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_t;

  state_t state;

  unit_t stack_mem [STACK_DEPTH];
  unit_t rd_data;

  logic [COUNT_W-1:0]  stack_count;
  logic [ROW_W-1:0]    current_row;
  logic [LEN_W-1:0]    next_col;
  logic [BUFCNT_W-1:0] buffer_count;
  logic [ALLOC_W-1:0]  alloc_counter;
  logic [LEN_W-1:0]    buf_len;

  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [ROW_W-1:0]    rsp_row;
  logic [COL_W-1:0]    rsp_col;
  logic [ALLOC_W-1:0]  rsp_alloc;
  logic [COUNT_W-1:0]  rsp_count;

  logic [LEN_W-1:0]    len_eff;
  logic [BUFCNT_W-1:0] init_eff;
  logic [BUFCNT_W-1:0] cfg_init;
  logic                accept;
  logic                cfg_write;
  logic                stack_empty;
  logic                stack_full;
  logic                buf_full;
  logic                no_space;
  logic                owned;
  logic                do_push;
  logic                do_pop;
  logic [STACK_AW-1:0] push_addr;
  logic [STACK_AW-1:0] pop_addr;

  // saturate configuration into its legal range
  always_comb begin
    if (buf_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (buf_len > LEN_W'(MAX_BUF_LEN)) begin
      len_eff = LEN_W'(MAX_BUF_LEN);
    end else begin
      len_eff = buf_len;
    end
    cfg_init = cfg.data[BUFCNT_W-1:0];
    if (cfg_init == '0) begin
      init_eff = BUFCNT_W'(1);
    end else if (cfg_init > BUFCNT_W'(MAX_BUFFERS)) begin
      init_eff = BUFCNT_W'(MAX_BUFFERS);
    end else begin
      init_eff = cfg_init;
    end
  end

  assign req.ready = (state == S_IDLE) && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid;

  assign stack_empty = (stack_count == '0);
  assign stack_full  = (stack_count >= COUNT_W'(STACK_DEPTH));
  assign buf_full    = (next_col >= len_eff);
  assign no_space    = (buffer_count >= BUFCNT_W'(MAX_BUFFERS));
  assign owned       = ({1'b0, req.free_row} < buffer_count) &&
                       ({1'b0, req.free_col} < len_eff);
  assign push_addr   = stack_count[STACK_AW-1:0];
  assign pop_addr    = STACK_AW'(stack_count - COUNT_W'(1));
  assign do_pop      = accept && (req.mode == MODE_ALLOC) && !stack_empty;
  assign do_push     = accept && (req.mode == MODE_FREE) && owned && !stack_full;

  // stack memory, registered read
  always_ff @(posedge clk) begin
    if (do_push) begin
      stack_mem[push_addr] <= '{row: req.free_row, col: req.free_col};
    end
    if (do_pop) begin
      rd_data <= stack_mem[pop_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      stack_count   <= '0;
      current_row   <= '0;
      next_col      <= '0;
      alloc_counter <= '0;
      buf_len       <= LEN_W'(MAX_BUF_LEN);
      buffer_count  <= BUFCNT_W'(1);
      rsp_valid     <= 1'b0;
    end else begin
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rsp_status <= ST_OK;
            rsp_row    <= '0;
            rsp_col    <= '0;
            rsp_alloc  <= alloc_counter;
            rsp_count  <= stack_count;
            rsp_valid  <= 1'b1;
            case (req.mode)
              MODE_ALLOC: begin
                rsp_alloc     <= alloc_counter + ALLOC_W'(1);
                alloc_counter <= alloc_counter + ALLOC_W'(1);
                if (!stack_empty) begin
                  stack_count <= stack_count - COUNT_W'(1);
                  rsp_count   <= stack_count - COUNT_W'(1);
                  rsp_valid   <= 1'b0;
                  state       <= S_POP;
                end else if (buf_full) begin
                  if (no_space) begin
                    rsp_status <= ST_OUT_OF_SPACE;
                  end else begin
                    current_row  <= buffer_count[ROW_W-1:0];
                    buffer_count <= buffer_count + BUFCNT_W'(1);
                    next_col     <= LEN_W'(1);
                    rsp_row      <= buffer_count[ROW_W-1:0];
                  end
                end else begin
                  rsp_row  <= current_row;
                  rsp_col  <= next_col[COL_W-1:0];
                  next_col <= next_col + LEN_W'(1);
                end
              end
              MODE_FREE: begin
                if (!owned) begin
                  rsp_status <= ST_NOT_OWNED;
                end else if (stack_full) begin
                  rsp_status <= ST_STACK_FULL;
                end else begin
                  stack_count <= stack_count + COUNT_W'(1);
                  rsp_count   <= stack_count + COUNT_W'(1);
                end
              end
              MODE_REINIT: begin
                stack_count   <= '0;
                current_row   <= '0;
                next_col      <= '0;
                alloc_counter <= '0;
                rsp_alloc     <= '0;
                rsp_count     <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_POP: begin
          rsp_row   <= rd_data.row;
          rsp_col   <= rd_data.col;
          rsp_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_write) begin
        unique case (cfg.index)
          CFG_BUF_LEN:         buf_len      <= cfg.data;
          CFG_INITIAL_BUFFERS: buffer_count <= init_eff;
          default: begin
          end
        endcase
      end
    end
  end

  assign rsp.valid           = rsp_valid;
  assign rsp.status          = rsp_status;
  assign rsp.unit_row        = rsp_row;
  assign rsp.unit_col        = rsp_col;
  assign rsp.units_allocated = rsp_alloc;
  assign rsp.returned_count  = rsp_count;

endmodule
